// ===== src/selective_repeat_sender_window_defines.svh =====
// Assertion macros for the selective repeat sender window.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
`define SRSW_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRSW_ASSERT_HOLDS(lbl, prop, msg)
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/srsw_pkg.sv =====
package srsw_pkg;

  localparam int SEQ_W          = 16;
  localparam int TICK_W         = 16;
  localparam int WIN_W          = 4;
  localparam int KIND_W         = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int OUT_DATA_W     = 40;
  localparam int OUT_PAD        = OUT_DATA_W - 2 * SEQ_W - 1;
  localparam int MAX_WINDOW_DEF = 8;

  localparam logic [WIN_W-1:0]  WINDOW_RESET  = 4'd4;
  localparam logic [SEQ_W-1:0]  TOTAL_RESET   = 16'd15;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd2;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NEW  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RETX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OUT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic              sent;
    logic              acked;
    logic [TICK_W-1:0] tick;
  } slot_t;

  typedef struct packed {
    logic              clear;
    logic              mark_sent;
    logic              mark_ack;
    logic              set_tick;
    logic [TICK_W-1:0] tick;
  } cell_op_t;

endpackage

// ===== src/selective_repeat_sender_window.sv =====
// Ring of R = 2*MAX_WINDOW slot cells, turned one cell per cycle while it rotates; a poll walk
// holds the ring while its result waits on m_tready. A new command is taken only from idle.
// Poll: take, seek to the first new slot, walk the whole ring, flush the pending result.
// Ack: out of window goes straight to the output; else seek to the acked slot (a duplicate ends
// there), turn back to the base, slide one slot per acked head, then wait for a free output.
// Reset (rst, synchronous): marks, counters and base cleared, registers to 4, 15 and 2.
`include "selective_repeat_sender_window_defines.svh"

module selective_repeat_sender_window #(
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [srsw_pkg::SEQ_W-1:0]            s_tdata,   // ack_seq
  input  logic                                  s_tuser,   // cmd
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [srsw_pkg::OUT_DATA_W-1:0]       m_tdata,   // seq, window_base, done_res
  output logic [srsw_pkg::KIND_W-1:0]           m_tuser,   // kind
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import srsw_pkg::*;

  localparam int RING = 2 * MAX_WINDOW;
  localparam int OW   = $clog2(RING);
  localparam int NW   = $clog2(MAX_WINDOW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PSEEK  = 3'd1;
  localparam logic [2:0] S_PWALK  = 3'd2;
  localparam logic [2:0] S_PEND   = 3'd3;
  localparam logic [2:0] S_ASEEK  = 3'd4;
  localparam logic [2:0] S_AALIGN = 3'd5;
  localparam logic [2:0] S_ASLIDE = 3'd6;
  localparam logic [2:0] S_AOUT   = 3'd7;

  logic [2:0]        state;
  logic [WIN_W-1:0]  win_reg;
  logic [SEQ_W-1:0]  total_count;
  logic [TICK_W-1:0] timeout_ticks;
  logic [SEQ_W-1:0]  base_seq;
  logic [SEQ_W-1:0]  next_num;
  logic [TICK_W-1:0] tick_cnt;
  logic [OW-1:0]     off;
  logic [OW-1:0]     wcnt;
  logic [OW-1:0]     p_lo;
  logic [OW-1:0]     p_hi;
  logic [OW-1:0]     a_off;
  logic [NW-1:0]     n_res;
  logic              pend_valid;
  logic [KIND_W-1:0] pend_kind;
  logic [SEQ_W-1:0]  pend_seq;
  logic [KIND_W-1:0] rkind;
  logic [SEQ_W-1:0]  rseq;
  logic [KIND_W-1:0] out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [SEQ_W-1:0]  out_base;
  logic              out_done;
  logic              out_last;

  slot_t    ring_q  [RING];
  slot_t    cell_d  [RING];
  cell_op_t cell_op [RING];
  cell_op_t tail_op;
  slot_t    head;

  logic [OW-1:0]     eff_w;
  logic [OW-1:0]     off_inc;
  logic [SEQ_W-1:0]  win_ext;
  logic [SEQ_W:0]    limit;
  logic [SEQ_W-1:0]  next_new;
  logic [SEQ_W-1:0]  ack_diff;
  logic              in_win;
  logic [TICK_W-1:0] head_age;
  logic              ph1;
  logic              ph2;
  logic              emit;
  logic              out_free;
  logic              out_load;
  logic              walk_go;
  logic              slide;
  logic              rotate;
  logic [SEQ_W-1:0]  walk_seq;
  logic              done_now;

  assign head = ring_q[0];

  for (genvar k = 0; k < RING; k++) begin : g_cell
    if (k == RING - 1) begin : g_tail
      assign cell_d[k]  = ring_q[0];
      assign cell_op[k] = tail_op;
    end else begin : g_body
      assign cell_d[k]  = ring_q[k+1];
      assign cell_op[k] = '0;
    end
    srsw_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (rotate),
      .op  (cell_op[k]),
      .d   (cell_d[k]),
      .q   (ring_q[k])
    );
  end

  always_comb begin
    if (32'(win_reg) > 32'(MAX_WINDOW)) begin
      eff_w = OW'(MAX_WINDOW);
    end else begin
      eff_w = OW'(win_reg);
    end
    off_inc  = (off == OW'(RING - 1)) ? '0 : off + 1'b1;
    win_ext  = SEQ_W'(eff_w);
    limit    = {1'b0, base_seq} + (SEQ_W+1)'(eff_w);
    if (({1'b0, next_num} < limit) && (next_num < total_count)) begin
      next_new = (limit < {1'b0, total_count}) ? limit[SEQ_W-1:0] : total_count;
    end else begin
      next_new = next_num;
    end
    ack_diff = s_tdata - base_seq;
    in_win   = (s_tdata >= base_seq) && (ack_diff < (win_ext << 1));
    head_age = tick_cnt - head.tick;
    ph1      = (off >= p_lo) && (off < p_hi) && !head.sent;
    ph2      = (off < p_lo) && head.sent && !head.acked && (head_age > timeout_ticks);
    emit     = (ph1 || ph2) && (n_res < NW'(MAX_WINDOW));
    out_free = !m_tvalid || m_tready;
    walk_go  = !(emit && pend_valid && !out_free);
    slide    = (base_seq < total_count) && head.acked;
    walk_seq = base_seq + SEQ_W'(off);
    done_now = base_seq >= total_count;

    rotate       = 1'b0;
    out_load     = 1'b0;
    tail_op      = '0;
    tail_op.tick = tick_cnt;
    unique case (state)
      S_PSEEK: begin
        rotate = (off != p_lo);
      end
      S_PWALK: begin
        rotate   = walk_go;
        out_load = walk_go && emit && pend_valid;
        if (emit) begin
          tail_op.set_tick  = 1'b1;
          tail_op.mark_sent = ph1;
        end
      end
      S_PEND: begin
        out_load = pend_valid && out_free;
      end
      S_ASEEK: begin
        rotate = 1'b1;
        tail_op.mark_ack = (off == a_off);
      end
      S_AALIGN: begin
        rotate = (off != '0);
      end
      S_ASLIDE: begin
        rotate        = slide;
        tail_op.clear = 1'b1;
      end
      S_AOUT: begin
        out_load = out_free;
      end
      default: begin
        rotate = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      win_reg       <= WINDOW_RESET;
      total_count   <= TOTAL_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      base_seq      <= '0;
      next_num      <= '0;
      tick_cnt      <= '0;
      off           <= '0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW:  win_reg       <= cfg_data[WIN_W-1:0];
          REG_TOTAL:   total_count   <= cfg_data[SEQ_W-1:0];
          REG_TIMEOUT: timeout_ticks <= cfg_data[TICK_W-1:0];
          default:     ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (rotate && (state != S_ASLIDE)) begin
        off <= off_inc;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rseq <= s_tdata;
            if (s_tuser == CMD_POLL) begin
              tick_cnt <= tick_cnt + 1'b1;
              p_lo     <= OW'(next_num - base_seq);
              p_hi     <= OW'(next_new - base_seq);
              next_num <= next_new;
              n_res    <= '0;
              state    <= S_PSEEK;
            end else if (in_win) begin
              a_off <= ack_diff[OW-1:0];
              state <= S_ASEEK;
            end else begin
              rkind <= KIND_OUT;
              state <= S_AOUT;
            end
          end
        end
        S_PSEEK: begin
          if (off == p_lo) begin
            wcnt  <= '0;
            state <= S_PWALK;
          end
        end
        S_PWALK: begin
          if (walk_go) begin
            if (emit) begin
              pend_valid <= 1'b1;
              pend_kind  <= ph1 ? KIND_NEW : KIND_RETX;
              pend_seq   <= walk_seq;
              n_res      <= n_res + 1'b1;
              if (pend_valid) begin
                out_kind <= pend_kind;
                out_seq  <= pend_seq;
                out_base <= base_seq;
                out_done <= done_now;
                out_last <= 1'b0;
              end
            end
            wcnt <= wcnt + 1'b1;
            if (wcnt == OW'(RING - 1)) begin
              state <= S_PEND;
            end
          end
        end
        S_PEND: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_kind   <= pend_kind;
            out_seq    <= pend_seq;
            out_base   <= base_seq;
            out_done   <= done_now;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_ASEEK: begin
          if (off == a_off) begin
            if (head.acked) begin
              rkind <= KIND_DUP;
              state <= S_AOUT;
            end else begin
              rkind <= KIND_ACK;
              state <= S_AALIGN;
            end
          end
        end
        S_AALIGN: begin
          if (off == '0) begin
            state <= S_ASLIDE;
          end
        end
        S_ASLIDE: begin
          if (slide) begin
            base_seq <= base_seq + 1'b1;
          end else begin
            if (next_num < base_seq) begin
              next_num <= base_seq;
            end
            state <= S_AOUT;
          end
        end
        S_AOUT: begin
          if (out_free) begin
            out_kind <= rkind;
            out_seq  <= rseq;
            out_base <= base_seq;
            out_done <= done_now;
            out_last <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{OUT_PAD{1'b0}}, out_done, out_base, out_seq};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  `SRSW_ASSERT_HOLDS(a_pend_in_poll, pend_valid |-> (state == S_PWALK || state == S_PEND), "pending result outside poll walk")
  `SRSW_ASSERT_HOLDS(a_slide_aligned, (state == S_ASLIDE) |-> (off == '0), "slide with ring not at base")
  `SRSW_ASSERT_HOLDS(a_next_not_below_base, (state == S_IDLE) |-> (next_num >= base_seq), "next below base when idle")
  `SRSW_ASSERT_NEXT(a_out_of_window, (state == S_IDLE && s_tvalid && s_tuser == CMD_ACK && !in_win), (state == S_AOUT && rkind == KIND_OUT), "ack outside window not flagged")

endmodule

// ===== src/srsw_cell.sv =====
module srsw_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  srsw_pkg::cell_op_t op,
  input  srsw_pkg::slot_t  d,
  output srsw_pkg::slot_t  q
);
  import srsw_pkg::*;

  logic              sent;
  logic              acked;
  logic [TICK_W-1:0] tick;
  slot_t             upd;

  always_comb begin
    upd = d;
    if (op.clear) begin
      upd.sent  = 1'b0;
      upd.acked = 1'b0;
    end
    if (op.mark_sent) begin
      upd.sent = 1'b1;
    end
    if (op.mark_ack) begin
      upd.acked = 1'b1;
    end
    if (op.set_tick) begin
      upd.tick = op.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent  <= 1'b0;
      acked <= 1'b0;
    end else if (en) begin
      sent  <= upd.sent;
      acked <= upd.acked;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tick <= upd.tick;
    end
  end

  assign q = '{sent: sent, acked: acked, tick: tick};

endmodule
